// ----- src/rkd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types and constants for the RSA key derivation block.
// ----------------------------------------------------------------------------
package rkd_pkg;

  localparam int WORD_W = 32;
  localparam int FIELD_W = 16;
  localparam int T_W = 34;
  localparam int CNT_W = 6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_EXP = 2'd1;
  localparam logic [1:0] STATUS_NO_INV = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_GCD,
    CMD_GCD_WB,
    CMD_DIV_LCM,
    CMD_LAM_WB,
    CMD_E_INIT,
    CMD_E_LOAD,
    CMD_E_NEXT,
    CMD_INV_INIT,
    CMD_DIV_INV,
    CMD_INV_MUL,
    CMD_INV_UPD,
    CMD_FIN_NOEXP,
    CMD_FIN_INV
  } rkd_cmd_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CHK    = 13'b0000000000010,
    S_GTEST  = 13'b0000000000100,
    S_GWAIT  = 13'b0000000001000,
    S_LDIV   = 13'b0000000010000,
    S_LWAIT  = 13'b0000000100000,
    S_LAMCHK = 13'b0000001000000,
    S_ETEST  = 13'b0000010000000,
    S_ITEST  = 13'b0000100000000,
    S_IWAIT  = 13'b0001000000000,
    S_IUPD   = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } rkd_state_t;

  typedef struct packed {
    logic div_done;
    logic pq_zero;
    logic gcd_done;
    logic gcd_one;
    logic lam_small;
    logic cand_ge_lam;
    logic r1_zero;
  } rkd_stat_t;

endpackage

// ----- src/rkd_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkd_divider
  import rkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              div_start,
  input  logic [WORD_W-1:0] div_dividend,
  input  logic [WORD_W-1:0] div_divisor,
  output logic              div_done,
  output logic [WORD_W-1:0] div_quo,
  output logic [WORD_W-1:0] div_rem
);

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[WORD_W-1]} - {1'b0, dvs_r};
    if (div_start) begin
      rem_nxt = '0;
      quo_nxt = div_dividend;
      cnt_nxt = CNT_W'(WORD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial[WORD_W]) begin
        rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (div_start) dvs_r <= div_divisor;
  end

  assign div_done = done_r;
  assign div_quo  = quo_r;
  assign div_rem  = rem_r;

endmodule

// ----- src/rkd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_datapath
// Operand registers, gcd / lcm / exponent / inverse arithmetic and results.
// ----------------------------------------------------------------------------
module rkd_datapath
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rkd_cmd_t           cmd,
  output rkd_stat_t          stat,
  input  logic [FIELD_W-1:0] in_prime_p,
  input  logic [FIELD_W-1:0] in_prime_q,
  output logic [WORD_W-1:0]  out_modulus_n,
  output logic [WORD_W-1:0]  out_lambda_value,
  output logic [WORD_W-1:0]  out_public_exp,
  output logic [WORD_W-1:0]  out_private_exp,
  output logic [1:0]         out_status
);

  localparam int PB = (PRIME_BITS > FIELD_W) ? FIELD_W : PRIME_BITS;
  localparam logic [FIELD_W-1:0] PMASK = FIELD_W'((33'd1 << PB) - 33'd1);

  logic [FIELD_W-1:0] p, q, pm1, qm1;
  logic [WORD_W-1:0]  x_r, y_r, prod_r, n_r, lam_r, cand_r, e_r, d_r;
  logic [WORD_W-1:0]  pm1_r, qm1_r;
  logic [1:0]         st_r;
  logic               gt_r;
  logic signed [T_W-1:0] t0_r, t1_r, mulp_r;
  logic signed [T_W-1:0] t_adj, t_fin, lam_s;
  logic signed [T_W-1:0] mul_full;

  logic              div_start;
  logic [WORD_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
  logic              div_done;

  assign p   = in_prime_p & PMASK;
  assign q   = in_prime_q & PMASK;
  assign pm1 = (p == '0) ? '0 : p - 1'b1;
  assign qm1 = (q == '0) ? '0 : q - 1'b1;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = x_r;
    div_divisor  = y_r;
    case (cmd)
      CMD_DIV_GCD: begin
        div_start    = 1'b1;
        div_dividend = (x_r > y_r) ? x_r : y_r;
        div_divisor  = (x_r > y_r) ? y_r : x_r;
      end
      CMD_DIV_LCM: begin
        div_start    = 1'b1;
        div_dividend = prod_r;
        div_divisor  = x_r | y_r;
      end
      CMD_DIV_INV: div_start = 1'b1;
      default: ;
    endcase
  end

  rkd_divider u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .div_rem      (div_rem)
  );

  assign mul_full = $signed({2'b00, div_quo}) * t1_r;
  assign lam_s    = $signed({2'b00, lam_r});
  assign t_adj    = t0_r[T_W-1] ? t0_r + lam_s : t0_r;
  assign t_fin    = (t_adj >= lam_s) ? t_adj - lam_s : t_adj;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        pm1_r  <= WORD_W'(pm1);
        qm1_r  <= WORD_W'(qm1);
        x_r    <= WORD_W'(pm1);
        y_r    <= WORD_W'(qm1);
        prod_r <= WORD_W'(pm1) * WORD_W'(qm1);
        n_r    <= WORD_W'(p) * WORD_W'(q);
        lam_r  <= '0;
        e_r    <= '0;
        d_r    <= '0;
        st_r   <= STATUS_OK;
      end
      CMD_DIV_GCD: gt_r <= x_r > y_r;
      CMD_GCD_WB: begin
        if (gt_r) x_r <= div_rem;
        else y_r <= div_rem;
      end
      CMD_LAM_WB: lam_r <= div_quo;
      CMD_E_INIT: cand_r <= lam_r >> 1;
      CMD_E_LOAD: begin
        x_r <= cand_r;
        y_r <= lam_r;
      end
      CMD_E_NEXT: cand_r <= cand_r + 1'b1;
      CMD_INV_INIT: begin
        e_r  <= cand_r;
        x_r  <= lam_r;
        y_r  <= cand_r;
        t0_r <= '0;
        t1_r <= T_W'(1);
      end
      CMD_INV_MUL: begin
        x_r    <= y_r;
        y_r    <= div_rem;
        mulp_r <= mul_full;
      end
      CMD_INV_UPD: begin
        t0_r <= t1_r;
        t1_r <= t0_r - mulp_r;
      end
      CMD_FIN_NOEXP: begin
        st_r <= STATUS_NO_EXP;
        e_r  <= '0;
        d_r  <= '0;
      end
      CMD_FIN_INV: begin
        if (x_r != WORD_W'(1) || t_fin == '0) begin
          st_r <= STATUS_NO_INV;
          d_r  <= '0;
        end else begin
          d_r <= t_fin[WORD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.div_done    = div_done;
    stat.pq_zero     = (pm1_r == '0) || (qm1_r == '0);
    stat.gcd_done    = (x_r == '0) || (y_r == '0);
    stat.gcd_one     = (x_r | y_r) == WORD_W'(1);
    stat.lam_small   = lam_r < WORD_W'(2);
    stat.cand_ge_lam = cand_r >= lam_r;
    stat.r1_zero     = y_r == '0;
  end

  assign out_modulus_n    = n_r;
  assign out_lambda_value = lam_r;
  assign out_public_exp   = e_r;
  assign out_private_exp  = d_r;
  assign out_status       = st_r;

endmodule

// ----- src/rkd_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_controller
// Sequencer for lcm, exponent search and modular inverse.
// ----------------------------------------------------------------------------
module rkd_controller
  import rkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_strobe,
  input  rkd_stat_t stat,
  output rkd_cmd_t  cmd
);

  rkd_state_t state_r, state_nxt;
  logic       exp_mode_r, exp_mode_nxt;

  always_comb begin
    state_nxt    = state_r;
    exp_mode_nxt = exp_mode_r;
    cmd          = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd          = CMD_LOAD;
          exp_mode_nxt = 1'b0;
          state_nxt    = S_CHK;
        end
      end
      S_CHK: state_nxt = stat.pq_zero ? S_LAMCHK : S_GTEST;
      S_GTEST: begin
        if (!stat.gcd_done) begin
          cmd       = CMD_DIV_GCD;
          state_nxt = S_GWAIT;
        end else if (!exp_mode_r) begin
          state_nxt = S_LDIV;
        end else if (stat.gcd_one) begin
          cmd       = CMD_INV_INIT;
          state_nxt = S_ITEST;
        end else begin
          cmd       = CMD_E_NEXT;
          state_nxt = S_ETEST;
        end
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd       = CMD_GCD_WB;
          state_nxt = S_GTEST;
        end
      end
      S_LDIV: begin
        cmd       = CMD_DIV_LCM;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (stat.div_done) begin
          cmd       = CMD_LAM_WB;
          state_nxt = S_LAMCHK;
        end
      end
      S_LAMCHK: begin
        if (stat.lam_small) begin
          cmd       = CMD_FIN_NOEXP;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_E_INIT;
          state_nxt = S_ETEST;
        end
      end
      S_ETEST: begin
        if (stat.cand_ge_lam) begin
          cmd       = CMD_FIN_NOEXP;
          state_nxt = S_DONE;
        end else begin
          cmd          = CMD_E_LOAD;
          exp_mode_nxt = 1'b1;
          state_nxt    = S_GTEST;
        end
      end
      S_ITEST: begin
        if (stat.r1_zero) begin
          cmd       = CMD_FIN_INV;
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_DIV_INV;
          state_nxt = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (stat.div_done) begin
          cmd       = CMD_INV_MUL;
          state_nxt = S_IUPD;
        end
      end
      S_IUPD: begin
        cmd       = CMD_INV_UPD;
        state_nxt = S_ITEST;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      exp_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      exp_mode_r <= exp_mode_nxt;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = state_r == S_DONE;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("result strobe not followed by idle");

endmodule

// ----- src/rsa_key_derivation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_key_derivation
// RSA modulus, Carmichael lambda, public and private exponent from two primes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_prime_p / in_prime_q and pulse start while busy is low; the word
//   is taken at that edge and busy rises. When the key values are ready,
//   out_strobe is high for exactly one cycle with out_modulus_n,
//   out_lambda_value, out_public_exp, out_private_exp and out_status; busy
//   drops in the cycle after the strobe.
//   Every gcd step, the lcm division and every inverse step use the shared
//   bit-serial divider; the coprime search runs a full gcd per candidate.
//   One word is in flight at a time.
//   The receiver cannot stall; results are valid only on the strobe cycle.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any word in progress.
// ----------------------------------------------------------------------------
module rsa_key_derivation
  import rkd_pkg::*;
#(
  parameter int PRIME_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_prime_p,
  input  logic [FIELD_W-1:0] in_prime_q,
  output logic               out_strobe,
  output logic [WORD_W-1:0]  out_modulus_n,
  output logic [WORD_W-1:0]  out_lambda_value,
  output logic [WORD_W-1:0]  out_public_exp,
  output logic [WORD_W-1:0]  out_private_exp,
  output logic [1:0]         out_status
);

  rkd_cmd_t  cmd;
  rkd_stat_t stat;

  rkd_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .stat       (stat),
    .cmd        (cmd)
  );

  rkd_datapath #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_prime_p       (in_prime_p),
    .in_prime_q       (in_prime_q),
    .out_modulus_n    (out_modulus_n),
    .out_lambda_value (out_lambda_value),
    .out_public_exp   (out_public_exp),
    .out_private_exp  (out_private_exp),
    .out_status       (out_status)
  );

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == STATUS_OK || out_status == STATUS_NO_EXP ||
                    out_status == STATUS_NO_INV))
    else $error("illegal status code");
  a_ok_has_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STATUS_OK) |-> out_private_exp != '0)
    else $error("ok status without private exponent");
  a_noexp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STATUS_NO_EXP) |-> out_public_exp == '0)
    else $error("no-exponent status with exponent set");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operand pairs (mostly prime) into rsa_key_derivation in random bursts
// and checks each strobed word against in-bench n, lambda, e, d and status.
// ----------------------------------------------------------------------------
module testbench;
  import rkd_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [FIELD_W-1:0] p;
    logic [FIELD_W-1:0] q;
    bit                 drain;
  } prime_pair_t;

  typedef struct {
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] lam;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] d;
    logic [1:0]        status;
  } key_word_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FIELD_W-1:0] in_prime_p;
  logic [FIELD_W-1:0] in_prime_q;
  logic               out_strobe;
  logic [WORD_W-1:0]  out_modulus_n;
  logic [WORD_W-1:0]  out_lambda_value;
  logic [WORD_W-1:0]  out_public_exp;
  logic [WORD_W-1:0]  out_private_exp;
  logic [1:0]         out_status;

  prime_pair_t pending_pairs[$];
  key_word_t   expected_keys[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_left = 0;
  int          burst_left = 1;

  rsa_key_derivation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_prime_p(in_prime_p), .in_prime_q(in_prime_q),
    .out_strobe(out_strobe), .out_modulus_n(out_modulus_n),
    .out_lambda_value(out_lambda_value), .out_public_exp(out_public_exp),
    .out_private_exp(out_private_exp), .out_status(out_status)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    while (x != 0 && y != 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    return (x > y) ? x : y;
  endfunction

  function automatic longint unsigned inverse_of(longint unsigned a, longint unsigned m);
    longint r0, r1, t0, t1, qv, rt, tt;
    r0 = m;
    r1 = a % m;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qv = r0 / r1;
      rt = r0 - qv * r1;
      tt = t0 - qv * t1;
      r0 = r1; r1 = rt; t0 = t1; t1 = tt;
    end
    if (r0 != 1) return 0;
    if (t0 < 0) t0 = t0 + m;
    return t0 % m;
  endfunction

  function automatic key_word_t derive_key(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
    key_word_t k;
    longint unsigned pm1, qm1, lam, cand, d;
    bit found;
    pm1 = (p == 0) ? 0 : p - 1;
    qm1 = (q == 0) ? 0 : q - 1;
    k.n = WORD_W'(p) * WORD_W'(q);
    lam = 0;
    found = 0;
    k.e = 0;
    k.d = 0;
    k.status = STATUS_OK;
    if (pm1 != 0 && qm1 != 0) lam = ((pm1 * qm1) / gcd_of(pm1, qm1)) & 64'hFFFF_FFFF;
    k.lam = WORD_W'(lam);
    if (lam < 2) begin
      k.status = STATUS_NO_EXP;
    end else begin
      cand = lam / 2;
      while (cand < lam && !found) begin
        if (gcd_of(cand, lam) == 1) found = 1;
        else cand++;
      end
      if (!found) begin
        k.status = STATUS_NO_EXP;
      end else begin
        k.e = WORD_W'(cand);
        d = inverse_of(cand, lam);
        k.d = WORD_W'(d);
        if (d == 0) k.status = STATUS_NO_INV;
      end
    end
    return k;
  endfunction

  function automatic bit prime_ok(int v);
    if (v < 2) return 0;
    for (int i = 2; i * i <= v; i++) if (v % i == 0) return 0;
    return 1;
  endfunction

  function automatic int pick_prime(int hi);
    int v;
    v = $urandom_range(hi, 2);
    while (!prime_ok(v)) v = $urandom_range(hi, 2);
    return v;
  endfunction

  task automatic add_pair(int p, int q, bit drain = 0);
    prime_pair_t w;
    w.p = FIELD_W'(p);
    w.q = FIELD_W'(q);
    w.drain = drain;
    pending_pairs.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_prime_p <= '0;
      in_prime_q <= '0;
    end else begin
      if (start && !busy) expected_keys.push_back(derive_key(in_prime_p, in_prime_q));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].drain &&
                       (expected_keys.size() > 0 || (start && !busy) || busy))) begin
          in_prime_p <= pending_pairs[0].p;
          in_prime_q <= pending_pairs[0].q;
          pending_pairs.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(8, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    key_word_t x;
    if (rst_n && out_strobe) begin
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected word n=%h", $time, out_modulus_n);
        errors++;
      end else begin
        x = expected_keys.pop_front();
        if (out_modulus_n !== x.n) begin
          $display("%0t: modulus_n exp %h got %h", $time, x.n, out_modulus_n);
          errors++;
        end
        if (out_lambda_value !== x.lam) begin
          $display("%0t: lambda_value exp %h got %h", $time, x.lam, out_lambda_value);
          errors++;
        end
        if (out_public_exp !== x.e) begin
          $display("%0t: public_exp exp %h got %h", $time, x.e, out_public_exp);
          errors++;
        end
        if (out_private_exp !== x.d) begin
          $display("%0t: private_exp exp %h got %h", $time, x.d, out_private_exp);
          errors++;
        end
        if (out_status !== x.status) begin
          $display("%0t: status exp %h got %h", $time, x.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int sel;
    rst_n = 1'b0;
    add_pair(0, 0);
    add_pair(1, 7);
    add_pair(2, 2);
    add_pair(3, 2);
    add_pair(2, 3);
    add_pair(3, 3);
    add_pair(5, 0);
    add_pair(65535, 65535);
    add_pair(65521, 65519);
    add_pair(65521, 2);
    add_pair(61, 53);
    add_pair(17, 17, 1);
    add_pair(16'hAAAA, 16'h5555);
    add_pair(251, 241);
    add_pair(65535, 1);
    for (int i = 0; i < 300; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 82) add_pair(pick_prime(251), pick_prime(251), (i % 97) == 50);
      else if (sel < 92) add_pair($urandom_range(65535, 0), $urandom_range(65535, 0));
      else if (sel < 96) add_pair(pick_prime(65535), pick_prime(65535));
      else add_pair($urandom_range(3, 0), pick_prime(251));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (start || busy || expected_keys.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_keys.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
